// ----- src/band_level_light_organ_core_assert.svh -----
// Assertion macros used by the band level light organ datapath.
`ifndef BAND_LEVEL_LIGHT_ORGAN_CORE_ASSERT_SVH
`define BAND_LEVEL_LIGHT_ORGAN_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define BLO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication checked only once the previous edge was also out of reset.
`define BLO_ASSERT_SETTLED(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        ($past(aresetn) && (cond)) |-> (conseq)) else $error(msg);

`endif

// ----- src/blo_pkg.sv -----
// Package with the types, constants and microcode program of the light organ core.
`default_nettype none

package blo_pkg;

    // Item fields and configuration register widths.
    localparam int MAG_W      = 16;
    localparam int LEVEL_W    = 20;
    localparam int DECAY_W    = 16;
    localparam int FLOOR_W    = 19;
    localparam int STEPS_W    = 4;
    localparam int CFG_W      = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int LAMP_COUNT = 4;
    localparam int M_DATA_W   = 8;

    // Frame layout.
    localparam int BINS_PER_FRAME = 32;
    localparam int BINS_PER_BAND  = 8;
    localparam int NUM_BANDS      = 4;
    localparam int BAND_W         = 2;
    localparam int POS_W          = $clog2(BINS_PER_FRAME + 1);

    // Datapath widths.
    localparam int PROD_W      = LEVEL_W + DECAY_W;
    localparam int LAMP_PROD_W = LEVEL_W + STEPS_W;
    localparam int UPC_W       = 3;

    // Reset values.
    localparam logic [DECAY_W-1:0] HOLD_DECAY_RESET    = DECAY_W'(62259);
    localparam logic [DECAY_W-1:0] CEILING_DECAY_RESET = DECAY_W'(65470);
    localparam logic [FLOOR_W-1:0] FLOOR_RESET         = '0;
    localparam logic [STEPS_W-1:0] STEPS_RESET         = STEPS_W'(3);
    localparam logic [LEVEL_W-1:0] CEILING_RESET       = LEVEL_W'(12000);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_DECAY    = 2'd0,
        REG_CEILING_DECAY = 2'd1,
        REG_FLOOR_LEVEL   = 2'd2,
        REG_LEVEL_STEPS   = 2'd3
    } cfg_reg_t;

    // Datapath operation of one microcode step.
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_HOLD_MUL,
        OP_HOLD_MAX,
        OP_CEIL_MUL,
        OP_CEIL_SET,
        OP_LAMP_MUL,
        OP_LAMP_CMP,
        OP_EMIT
    } op_t;

    // Jump condition of one microcode step.
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_BAND_MORE,
        JC_NO_FRAME_END
    } jump_cond_t;

    typedef struct packed {
        op_t              op;
        jump_cond_t       cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        op_t op;
    } ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic frame_end;
        logic band_more;
        logic out_busy;
    } status_t;

    // Microcode program. The accept step loops on itself until the last bin of a
    // frame arrives; the two band loops reuse one step pair for all four bands.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t word;
        unique case (addr)
            3'd0: word = '{op: OP_ACCEPT,   cond: JC_NO_FRAME_END, target: 3'd0};
            3'd1: word = '{op: OP_HOLD_MUL, cond: JC_NEXT,         target: 3'd0};
            3'd2: word = '{op: OP_HOLD_MAX, cond: JC_BAND_MORE,    target: 3'd1};
            3'd3: word = '{op: OP_CEIL_MUL, cond: JC_NEXT,         target: 3'd0};
            3'd4: word = '{op: OP_CEIL_SET, cond: JC_NEXT,         target: 3'd0};
            3'd5: word = '{op: OP_LAMP_MUL, cond: JC_NEXT,         target: 3'd0};
            3'd6: word = '{op: OP_LAMP_CMP, cond: JC_BAND_MORE,    target: 3'd5};
            3'd7: word = '{op: OP_EMIT,     cond: JC_ALWAYS,       target: 3'd0};
            default: word = '{op: OP_ACCEPT, cond: JC_NEXT, target: 3'd0};
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

// ----- src/band_level_light_organ_core.sv -----
// Top level of the band level light organ: sequencer plus datapath.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_tvalid/s_tready   s_tdata = bin magnitude, s_tlast = frame end
//   m_        out        m_tvalid/m_tready   m_tdata = four lamp bits
//   cfg_      in         cfg_we              cfg_index selects register, cfg_data value
//
// A bin that does not end a frame is taken in the accept step alone.
// The bin that ends a frame runs through accept, two steps per band for the
// hold decay multiply and max, two for the ceiling update, two per band for the
// lamp compare, and one emit step; the one 20x16 decay multiplier is shared
// by the hold and ceiling multiply steps.
// Reset is synchronous and active low; it restores the register defaults, clears
// sums and held levels, and sets the gain ceiling to 12000.
// The emit step waits while the output register still holds an untaken item;
// the next frame's bins are accepted while a finished result waits on m_.
`default_nettype none

module band_level_light_organ_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [blo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blo_pkg::CFG_W-1:0]      cfg_data,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [blo_pkg::MAG_W-1:0]      s_tdata,   // [15:0] bin_magnitude
    input  logic                           s_tlast,   // frame_last
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [blo_pkg::M_DATA_W-1:0]   m_tdata    // [0] lamp_band1, [1] lamp_band2,
                                                      // [2] lamp_band3, [3] lamp_band4,
                                                      // [7:4] zero
);

    // The sequencer steps through the program and tells the datapath what to do;
    // the datapath reports frame end, band loop progress and output backpressure.
    blo_pkg::ctrl_t   ctrl;
    blo_pkg::status_t status;

    blo_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    blo_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- src/blo_sequencer.sv -----
// Microcode sequencer: step counter, program table and jump logic.
`default_nettype none

module blo_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  blo_pkg::status_t  status,
    output blo_pkg::ctrl_t    ctrl
);

    logic [blo_pkg::UPC_W-1:0] pc_reg;
    logic [blo_pkg::UPC_W-1:0] pc_next;
    blo_pkg::ucode_t           word;
    logic                      take;
    logic                      stall;

    assign word    = blo_pkg::ucode_rom(pc_reg);
    assign ctrl.op = word.op;

    // The emit step holds while the output register still holds an untaken item.
    assign stall = (word.op == blo_pkg::OP_EMIT) && status.out_busy;

    always_comb begin
        unique case (word.cond)
            blo_pkg::JC_NEXT:         take = 1'b0;
            blo_pkg::JC_ALWAYS:       take = 1'b1;
            blo_pkg::JC_BAND_MORE:    take = status.band_more;
            blo_pkg::JC_NO_FRAME_END: take = !status.frame_end;
            default:                  take = 1'b0;
        endcase
        if (stall) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = word.target;
        end else begin
            pc_next = pc_reg + blo_pkg::UPC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/blo_datapath.sv -----
// Datapath: band sums, held levels, gain ceiling, shared multiplier and lamp compare.
`default_nettype none

`include "band_level_light_organ_core_assert.svh"

module blo_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  blo_pkg::ctrl_t                  ctrl,
    output blo_pkg::status_t                status,
    input  logic                            cfg_we,
    input  logic [blo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blo_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [blo_pkg::MAG_W-1:0]       s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [blo_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int LW = blo_pkg::LEVEL_W;

    // Configuration registers.
    logic [blo_pkg::DECAY_W-1:0] hold_decay_reg;
    logic [blo_pkg::DECAY_W-1:0] ceil_decay_reg;
    logic [blo_pkg::FLOOR_W-1:0] floor_reg;
    logic [blo_pkg::STEPS_W-1:0] steps_reg;

    // Frame state.
    logic [blo_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [LW-1:0]              acc_reg [blo_pkg::NUM_BANDS];
    logic [LW-1:0]              acc_next [blo_pkg::NUM_BANDS];
    logic [LW-1:0]              held_reg [blo_pkg::NUM_BANDS];
    logic [LW-1:0]              held_next [blo_pkg::NUM_BANDS];
    logic [LW-1:0]              ceil_reg, ceil_next;
    logic [LW-1:0]              top_reg, top_next;
    logic                       over_reg, over_next;
    logic [blo_pkg::BAND_W-1:0] band_reg, band_next;
    logic [blo_pkg::LAMP_COUNT-1:0] lamp_reg, lamp_next;
    logic                       m_valid_reg, m_valid_next;

    // Payload registers.
    logic [blo_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [blo_pkg::LAMP_PROD_W-1:0] lamp_prod_reg, lamp_prod_next;
    logic                            lamp_pos_reg, lamp_pos_next;
    logic [blo_pkg::LAMP_COUNT-1:0]  m_lamp_reg, m_lamp_next;

    // Combinational helpers.
    logic                            fire;
    logic [blo_pkg::POS_W-1:0]       pos_band;
    logic                            in_band;
    logic [blo_pkg::BAND_W-1:0]      acc_idx;
    logic [LW-1:0]                   acc_rd;
    logic [LW:0]                     acc_sum;
    logic [LW-1:0]                   acc_sat;
    logic [LW-1:0]                   mul_a;
    logic [blo_pkg::DECAY_W-1:0]     mul_b;
    logic [LW-1:0]                   decayed;
    logic [LW-1:0]                   level;
    logic [LW-1:0]                   lvl_rd;
    logic [LW-1:0]                   floor_ext;
    logic [LW-1:0]                   lvl_diff;
    logic [LW-1:0]                   span;
    logic                            ceil_ok;
    logic [blo_pkg::LAMP_PROD_W-1:0] thresh;
    logic                            out_load;

    assign s_tready = (ctrl.op == blo_pkg::OP_ACCEPT);
    assign fire     = s_tvalid && s_tready;

    assign status.frame_end = fire && s_tlast;
    assign status.band_more = (band_reg != blo_pkg::BAND_W'(blo_pkg::NUM_BANDS - 1));
    assign status.out_busy  = m_valid_reg && !m_tready;

    // Bin 0 and bins past the last band do not count.
    assign pos_band = blo_pkg::POS_W'(pos_reg / blo_pkg::BINS_PER_BAND);
    assign in_band  = (pos_reg != '0)
                   && (pos_reg < blo_pkg::POS_W'(blo_pkg::BINS_PER_FRAME))
                   && (pos_band < blo_pkg::POS_W'(blo_pkg::NUM_BANDS));

    assign acc_idx = (ctrl.op == blo_pkg::OP_ACCEPT) ? pos_band[blo_pkg::BAND_W-1:0]
                                                     : band_reg;
    assign acc_rd  = acc_reg[acc_idx];
    assign acc_sum = {1'b0, acc_rd} + (LW + 1)'(s_tdata);
    assign acc_sat = acc_sum[LW] ? {LW{1'b1}} : acc_sum[LW-1:0];

    // One shared multiplier serves both decay products.
    assign lvl_rd  = held_reg[band_reg];
    assign mul_a   = (ctrl.op == blo_pkg::OP_CEIL_MUL) ? ceil_reg : lvl_rd;
    assign mul_b   = (ctrl.op == blo_pkg::OP_CEIL_MUL) ? ceil_decay_reg : hold_decay_reg;
    assign decayed = prod_reg[blo_pkg::PROD_W-1:blo_pkg::DECAY_W];
    assign level   = (acc_rd < decayed) ? decayed : acc_rd;

    // The lamp test compares (level - floor) * steps with one or two spans,
    // which is the same as the truncated quotient exceeding zero or one.
    assign floor_ext = LW'(floor_reg);
    assign lvl_diff  = lvl_rd - floor_ext;
    assign span      = ceil_reg - floor_ext;
    assign ceil_ok   = ceil_reg > floor_ext;
    assign thresh    = (band_reg == '0) ? blo_pkg::LAMP_PROD_W'({span, 1'b0})
                                        : blo_pkg::LAMP_PROD_W'(span);

    assign out_load = (ctrl.op == blo_pkg::OP_EMIT) && !status.out_busy;

    always_comb begin
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        ceil_next      = ceil_reg;
        top_next       = top_reg;
        over_next      = over_reg;
        band_next      = band_reg;
        lamp_next      = lamp_reg;
        prod_next      = prod_reg;
        lamp_prod_next = lamp_prod_reg;
        lamp_pos_next  = lamp_pos_reg;
        m_lamp_next    = m_lamp_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        unique case (ctrl.op)
            blo_pkg::OP_ACCEPT: begin
                if (fire) begin
                    if (in_band) begin
                        acc_next[acc_idx] = acc_sat;
                    end
                    if (s_tlast) begin
                        pos_next = '0;
                    end else if (pos_reg < blo_pkg::POS_W'(blo_pkg::BINS_PER_FRAME)) begin
                        pos_next = pos_reg + blo_pkg::POS_W'(1);
                    end
                end
            end
            blo_pkg::OP_HOLD_MUL, blo_pkg::OP_CEIL_MUL: begin
                prod_next = blo_pkg::PROD_W'(mul_a) * blo_pkg::PROD_W'(mul_b);
            end
            blo_pkg::OP_HOLD_MAX: begin
                held_next[band_reg] = level;
                acc_next[band_reg]  = '0;
                if (level > ceil_reg) begin
                    over_next = 1'b1;
                end
                if (level > top_reg) begin
                    top_next = level;
                end
                band_next = band_reg + blo_pkg::BAND_W'(1);
            end
            blo_pkg::OP_CEIL_SET: begin
                ceil_next = over_reg ? top_reg : decayed;
            end
            blo_pkg::OP_LAMP_MUL: begin
                lamp_pos_next  = lvl_rd > floor_ext;
                lamp_prod_next = blo_pkg::LAMP_PROD_W'(lvl_diff)
                               * blo_pkg::LAMP_PROD_W'(steps_reg);
            end
            blo_pkg::OP_LAMP_CMP: begin
                lamp_next[band_reg] = lamp_pos_reg && ceil_ok && (lamp_prod_reg >= thresh);
                band_next           = band_reg + blo_pkg::BAND_W'(1);
            end
            blo_pkg::OP_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_lamp_next  = lamp_reg;
                    over_next    = 1'b0;
                    top_next     = '0;
                end
            end
            default: begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_decay_reg <= blo_pkg::HOLD_DECAY_RESET;
            ceil_decay_reg <= blo_pkg::CEILING_DECAY_RESET;
            floor_reg      <= blo_pkg::FLOOR_RESET;
            steps_reg      <= blo_pkg::STEPS_RESET;
        end else if (cfg_we) begin
            unique case (blo_pkg::cfg_reg_t'(cfg_index))
                blo_pkg::REG_HOLD_DECAY:    hold_decay_reg <= cfg_data[blo_pkg::DECAY_W-1:0];
                blo_pkg::REG_CEILING_DECAY: ceil_decay_reg <= cfg_data[blo_pkg::DECAY_W-1:0];
                blo_pkg::REG_FLOOR_LEVEL:   floor_reg      <= cfg_data[blo_pkg::FLOOR_W-1:0];
                blo_pkg::REG_LEVEL_STEPS:   steps_reg      <= cfg_data[blo_pkg::STEPS_W-1:0];
                default:                    steps_reg      <= steps_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            acc_reg     <= '{default: '0};
            held_reg    <= '{default: '0};
            ceil_reg    <= blo_pkg::CEILING_RESET;
            top_reg     <= '0;
            over_reg    <= 1'b0;
            band_reg    <= '0;
            lamp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            held_reg    <= held_next;
            ceil_reg    <= ceil_next;
            top_reg     <= top_next;
            over_reg    <= over_next;
            band_reg    <= band_next;
            lamp_reg    <= lamp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        lamp_prod_reg <= lamp_prod_next;
        lamp_pos_reg  <= lamp_pos_next;
        m_lamp_reg    <= m_lamp_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = blo_pkg::M_DATA_W'(m_lamp_reg);

    `BLO_ASSERT_SETTLED(a_out_from_emit, $rose(m_valid_reg), $past(ctrl.op == blo_pkg::OP_EMIT), "result appeared outside the emit step")
    `BLO_ASSERT_SETTLED(a_ceil_from_set, !$stable(ceil_reg), $past(ctrl.op == blo_pkg::OP_CEIL_SET), "ceiling changed outside the ceiling update step")
    `BLO_ASSERT(a_sums_cleared, (ctrl.op == blo_pkg::OP_EMIT) |-> (acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0 && acc_reg[3] == '0), "band sums not cleared before emit")
    `BLO_ASSERT(a_pos_idle, (ctrl.op != blo_pkg::OP_ACCEPT) |-> (pos_reg == '0), "bin position not rewound during frame end processing")

endmodule

`default_nettype wire

// ----- tb/sv/band_level_light_organ_core_tb.sv -----
// Self-checking testbench for the band level light organ core: stream stimulus, model, checks.
`default_nettype none

module band_level_light_organ_core_tb;
    import blo_pkg::*;

    // One row of the directed table. Where known is set, the lamp word is typed in
    // by hand; otherwise the expectation comes from the lamp model below.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
        logic             known;
        logic [3:0]       lamps;
    } bin_row_t;

    localparam int DIRECTED_ROWS = 18;
    localparam int PHASES        = 8;
    localparam int PHASE_BINS    = 250;
    localparam int SETTLE_CYCLES = 30;    // room for the frame end steps
    localparam int QUIET_LIMIT   = 2000;  // cycles without any accepted item
    localparam int PRINT_LIMIT   = 40;

    // The first row is a frame made of bin 0 alone, so every band is empty and
    // every lamp stays dark. The second puts a full scale bin into band 1, which
    // lifts the ceiling to that level and maps band 1 to the top step. The rest
    // exercise decay alone, single bits on the low eight magnitude lines and a band 2 hit.
    bin_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'd65535, 1'b1, 1'b1, 4'b0000},
        '{16'd0,     1'b0, 1'b0, 4'b0000},
        '{16'd65535, 1'b1, 1'b1, 4'b0001},
        '{16'd0,     1'b0, 1'b0, 4'b0000},
        '{16'd0,     1'b1, 1'b0, 4'b0000},
        '{16'd7,     1'b0, 1'b0, 4'b0000},
        '{16'd1,     1'b0, 1'b0, 4'b0000},
        '{16'd2,     1'b0, 1'b0, 4'b0000},
        '{16'd4,     1'b0, 1'b0, 4'b0000},
        '{16'd8,     1'b0, 1'b0, 4'b0000},
        '{16'd16,    1'b0, 1'b0, 4'b0000},
        '{16'd32,    1'b0, 1'b0, 4'b0000},
        '{16'd64,    1'b0, 1'b0, 4'b0000},
        '{16'd128,   1'b1, 1'b0, 4'b0000},
        '{16'd0,     1'b0, 1'b0, 4'b0000},
        '{16'd32768, 1'b0, 1'b0, 4'b0000},
        '{16'd16384, 1'b0, 1'b0, 4'b0000},
        '{16'd65535, 1'b1, 1'b0, 4'b0000}
    };

    // Clock, reset and all block inputs start at known values.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_index = REG_HOLD_DECAY;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [MAG_W-1:0]      s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    band_level_light_organ_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Lamp model: its own copy of the registers and of the frame state.
    logic [DECAY_W-1:0] hold_decay_r;
    logic [DECAY_W-1:0] ceil_decay_r;
    logic [FLOOR_W-1:0] floor_r;
    logic [STEPS_W-1:0] steps_r;
    logic [5:0]         bin_pos;
    logic [LEVEL_W-1:0] band_sum [NUM_BANDS];
    logic [LEVEL_W-1:0] held     [NUM_BANDS];
    logic [LEVEL_W-1:0] ceiling;

    // Lamp words still owed by the block, oldest first.
    logic [3:0] pending_lamps [$];

    int   mismatches    = 0;
    int   lamps_checked = 0;
    int   bins_sent     = 0;
    int   frames_sent   = 0;
    int   stall_left    = 0;
    int   quiet_cycles  = 0;
    logic idle_on       = 1'b1;

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic logic [LEVEL_W-1:0] q16_scale(input logic [LEVEL_W-1:0] v,
                                                     input logic [DECAY_W-1:0] f);
        logic [PROD_W-1:0] p;
        p = {{DECAY_W{1'b0}}, v} * {{LEVEL_W{1'b0}}, f};
        return p[PROD_W-1:DECAY_W];
    endfunction

    // Step index of a band level between floor and ceiling; zero when either the
    // ceiling or the level is not above the floor.
    function automatic logic [LAMP_PROD_W-1:0] level_step(input logic [LEVEL_W-1:0] lvl);
        logic [LEVEL_W-1:0]     base;
        logic [LAMP_PROD_W-1:0] scaled;
        base = LEVEL_W'(floor_r);
        if (ceiling <= base || lvl <= base)
            return '0;
        scaled = LAMP_PROD_W'(lvl - base) * LAMP_PROD_W'(steps_r);
        return scaled / LAMP_PROD_W'(ceiling - base);
    endfunction

    task automatic model_reset();
        hold_decay_r = HOLD_DECAY_RESET;
        ceil_decay_r = CEILING_DECAY_RESET;
        floor_r      = FLOOR_RESET;
        steps_r      = STEPS_RESET;
        bin_pos      = '0;
        ceiling      = CEILING_RESET;
        for (int i = 0; i < NUM_BANDS; i++) begin
            band_sum[i] = '0;
            held[i]     = '0;
        end
    endtask

    // Folds one accepted bin into the model; on a frame end it returns the lamp word.
    task automatic absorb_bin(input logic [MAG_W-1:0] mag, input logic last,
                              output logic produced, output logic [3:0] lamps);
        logic [LEVEL_W:0]   total;
        logic [LEVEL_W-1:0] decayed;
        logic [LEVEL_W-1:0] lvl [NUM_BANDS];
        logic [LEVEL_W-1:0] top;
        logic               over;
        produced = 1'b0;
        lamps    = '0;
        // Bin 0 is skipped; bins past the end of band 4 are dropped and the
        // position stops counting at the frame length.
        if (bin_pos != 0 && bin_pos < BINS_PER_FRAME) begin
            total = band_sum[bin_pos[4:3]] + mag;
            band_sum[bin_pos[4:3]] = total[LEVEL_W] ? {LEVEL_W{1'b1}} : total[LEVEL_W-1:0];
        end
        if (bin_pos < BINS_PER_FRAME)
            bin_pos++;
        if (!last)
            return;
        top  = '0;
        over = 1'b0;
        for (int i = 0; i < NUM_BANDS; i++) begin
            decayed = q16_scale(held[i], hold_decay_r);
            lvl[i]  = (band_sum[i] < decayed) ? decayed : band_sum[i];
            if (lvl[i] > ceiling)
                over = 1'b1;
            if (lvl[i] > top)
                top = lvl[i];
        end
        ceiling  = over ? top : q16_scale(ceiling, ceil_decay_r);
        lamps[0] = level_step(lvl[0]) > 1;
        for (int i = 1; i < NUM_BANDS; i++)
            lamps[i] = level_step(lvl[i]) > 0;
        for (int i = 0; i < NUM_BANDS; i++) begin
            held[i]     = lvl[i];
            band_sum[i] = '0;
        end
        bin_pos  = '0;
        produced = 1'b1;
    endtask

    // Offers one bin, with an occasional gap before it, and waits for the handshake.
    // A typed lamp word, where given, stands in for the model's expectation.
    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last,
                            input logic typed, input logic [3:0] typed_lamps);
        logic       produced;
        logic [3:0] lamps;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mag;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bins_sent++;
        absorb_bin(mag, last, produced, lamps);
        if (produced) begin
            frames_sent++;
            pending_lamps.push_back(typed ? typed_lamps : lamps);
        end
    endtask

    // Writes all four registers on consecutive edges. Unused upper data bits carry
    // random values, since the block keeps only the register's own width.
    task automatic load_settings(input logic [DECAY_W-1:0] hd, input logic [DECAY_W-1:0] cd,
                                 input logic [FLOOR_W-1:0] fl, input logic [STEPS_W-1:0] st);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HOLD_DECAY;
        cfg_data  <= {3'($urandom), hd};
        @(posedge aclk);
        cfg_index <= REG_CEILING_DECAY;
        cfg_data  <= {3'($urandom), cd};
        @(posedge aclk);
        cfg_index <= REG_FLOOR_LEVEL;
        cfg_data  <= fl;
        @(posedge aclk);
        cfg_index <= REG_LEVEL_STEPS;
        cfg_data  <= {15'($urandom), st};
        @(posedge aclk);
        cfg_we       <= 1'b0;
        hold_decay_r = hd;
        ceil_decay_r = cd;
        floor_r      = fl;
        steps_r      = st;
    endtask

    // Lets every owed lamp word arrive, then gives the block time to finish any
    // frame end work before the registers change or the run ends.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_lamps.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_lamp_word(input logic [M_DATA_W-1:0] word);
        logic [3:0] want;
        if (pending_lamps.size() == 0) begin
            flag_mismatch("lamp word with none owed", word, 0);
            return;
        end
        want = pending_lamps.pop_front();
        for (int i = 0; i < NUM_BANDS; i++)
            if (word[i] !== want[i])
                flag_mismatch($sformatf("lamp_band%0d", i + 1), word[i], want[i]);
        if (word[M_DATA_W-1:4] !== '0)
            flag_mismatch("lamp word pad bits", word[M_DATA_W-1:4], 0);
        lamps_checked++;
    endtask

    // Result side: every accepted lamp word is compared with the oldest one owed.
    // Ready drops in bursts of random length while idling is on.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_lamp_word(m_tdata);
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: a correct run never goes long without an item moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles", QUIET_LIMIT);
            $display("band_level_light_organ_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int               phase_bins;
        int               len;
        int               pick;
        logic [MAG_W-1:0] amp;
        logic [DECAY_W-1:0] hd;
        logic [DECAY_W-1:0] cd;
        logic [FLOOR_W-1:0] fl;
        logic [STEPS_W-1:0] st;

        model_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, run with the register values left by reset.
        foreach (directed_rows[r])
            send_bin(directed_rows[r].mag, directed_rows[r].last,
                     directed_rows[r].known, directed_rows[r].lamps);
        drain();

        // Random frames under a series of register settings: the reset values,
        // the slowest and fastest decays, a floor above any reachable level,
        // zero steps and random mixes. The last setting runs with no idling.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin hd = HOLD_DECAY_RESET; cd = CEILING_DECAY_RESET; fl = '0; st = 4'd3; end
                1: begin hd = 16'hFFFF; cd = 16'hFFFF; fl = '0; st = 4'd15; end
                2: begin hd = 16'h0000; cd = 16'h0000; fl = '0; st = 4'd1; end
                3: begin
                    hd = 16'($urandom); cd = 16'($urandom);
                    fl = 19'($urandom_range(0, 20000)); st = 4'($urandom_range(1, 15));
                end
                4: begin hd = 16'hFFFF; cd = 16'hFFFF; fl = 19'h7FFFF; st = 4'd15; end
                5: begin
                    hd = 16'($urandom); cd = 16'($urandom);
                    fl = 19'($urandom_range(0, 4000)); st = 4'd0;
                end
                6: begin
                    hd = 16'($urandom); cd = 16'($urandom_range(60000, 65535));
                    fl = 19'($urandom_range(0, 100000)); st = 4'($urandom);
                end
                default: begin
                    hd = 16'($urandom); cd = 16'($urandom);
                    fl = 19'($urandom_range(0, 8000)); st = 4'($urandom_range(1, 15));
                end
            endcase
            load_settings(hd, cd, fl, st);

            phase_bins = 0;
            while (phase_bins < PHASE_BINS) begin
                // Half of the frames are full; the rest end early or run past the last band.
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    len = BINS_PER_FRAME;
                else if (pick < 17)
                    len = $urandom_range(1, BINS_PER_FRAME - 1);
                else
                    len = $urandom_range(BINS_PER_FRAME + 1, BINS_PER_FRAME + 8);
                // One loudness per frame, so that quiet and loud frames mix at random.
                case ($urandom_range(0, 4))
                    0: amp = 16'd0;
                    1: amp = 16'd255;
                    2: amp = 16'd4095;
                    default: amp = 16'hFFFF;
                endcase
                idle_on <= (phase != PHASES - 1) && ($urandom_range(0, 4) != 0);
                for (int b = 0; b < len; b++)
                    send_bin(16'($urandom_range(0, amp)), b == len - 1, 1'b0, 4'b0000);
                phase_bins += len;
            end
            drain();
        end

        $display("Sent %0d bins in %0d frames under %0d register settings.",
                 bins_sent, frames_sent, PHASES + 1);
        $display("Compared %0d lamp words, %0d mismatches.", lamps_checked, mismatches);
        if (mismatches == 0)
            $display("band_level_light_organ_core_tb OK");
        else
            $display("band_level_light_organ_core_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
